// ----- rtl/ohlc_pkg.sv -----
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared types and constants for the OHLC time bar aggregator.
// ----------------------------------------------------------------------------
package ohlc_pkg;

  localparam int unsigned PER_W  = 17;
  localparam int unsigned INST_W = 16;
  localparam int unsigned MID_W  = 33;
  localparam int unsigned VOL_W  = 48;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned PX_W   = 32;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned SLOT_W = 2;
  localparam int unsigned CIDX_W = 4;
  localparam int unsigned CDAT_W = 16;
  localparam int unsigned RADIX_BITS = 4;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_INST_BASE = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_PER_BASE  = 4'd4;
  localparam logic [CIDX_W-1:0] CFG_END       = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_UPD
  } state_t;

  function automatic logic [PER_W-1:0] period_secs(input logic [CODE_W-1:0] code);
    logic [PER_W-1:0] p;
    begin
      case (code)
        3'd2:    p = 17'd300;
        3'd3:    p = 17'd900;
        3'd4:    p = 17'd1800;
        3'd5:    p = 17'd3600;
        3'd6:    p = 17'd14400;
        3'd7:    p = 17'd86400;
        default: p = 17'd60;
      endcase
      return p;
    end
  endfunction

endpackage

// ----- rtl/ohlc_bar_aggregator_unit.sv -----
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator_unit
// Open/high/low/close time bars from market ticks over configured slots.
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: s_tuser carries op (tick or flush), s_tdata the
// tick fields. Each slot is a configured instrument and period code written
// over cfg_* while the block is idle; a write drops that slot's bar.
// Bar beats leave on m_*: m_tuser is the slot, m_tlast marks the final bar of
// one input beat. Bars come out in slot order.
// An input beat is scanned slot by slot; each slot whose bar rolls over also
// passes through the shared remainder unit that aligns the bar start (4
// quotient bits per cycle), and a bar may wait for the single output
// register to drain.
// s_tready and cfg_ready are high only while the sequencer is idle; a
// finished bar may still sit in the output register then. When the receiver
// stalls, the sequencer holds at the next bar to send.
// Reset clears the slot settings and all open bars; no bar is emitted.
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator_unit #(
  parameter int unsigned NUM_SLOTS = 4,
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // instrument, time_sec, bid_price, ask_price, has_trade, trade_size
  input  logic [((113+TIME_BITS+7)/8)*8-1:0]    s_tdata,
  // op
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // bar_instrument, bar_period, bar_start, open_mid, high_mid, low_mid,
  // close_mid, volume, tick_total
  output logic [((231+TIME_BITS+7)/8)*8-1:0]    m_tdata,
  // slot
  output logic [ohlc_pkg::SLOT_W-1:0]           m_tuser,
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ohlc_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [ohlc_pkg::CDAT_W-1:0]           cfg_data
);
  import ohlc_pkg::*;

  localparam int unsigned OUT_W   = ((231 + TIME_BITS + 7) / 8) * 8;
  localparam int unsigned DSTEPS  = (TIME_BITS + RADIX_BITS - 1) / RADIX_BITS;
  localparam int unsigned DW      = DSTEPS * RADIX_BITS;
  localparam int unsigned CNT_W   = (DSTEPS > 1) ? $clog2(DSTEPS) : 1;
  localparam int unsigned SIDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned T_LO    = INST_W;
  localparam int unsigned B_LO    = T_LO + TIME_BITS;
  localparam int unsigned A_LO    = B_LO + PX_W;
  localparam int unsigned H_LO    = A_LO + PX_W;
  localparam int unsigned Z_LO    = H_LO + 1;
  localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(DSTEPS - 1);

  state_t state, state_next;

  logic [INST_W-1:0]    slot_inst [NUM_SLOTS];
  logic [CODE_W-1:0]    slot_per  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] bar_open;
  logic [TIME_BITS:0]   bnd       [NUM_SLOTS];
  logic [TIME_BITS-1:0] start_t   [NUM_SLOTS];
  logic [MID_W-1:0]     open_v    [NUM_SLOTS];
  logic [MID_W-1:0]     high_v    [NUM_SLOTS];
  logic [MID_W-1:0]     low_v     [NUM_SLOTS];
  logic [MID_W-1:0]     close_v   [NUM_SLOTS];
  logic [VOL_W-1:0]     vol_v     [NUM_SLOTS];
  logic [TICK_W-1:0]    tick_v    [NUM_SLOTS];

  logic                 it_op;
  logic [INST_W-1:0]    it_inst;
  logic [TIME_BITS-1:0] it_t;
  logic [MID_W-1:0]     it_mid;
  logic                 it_trade;
  logic [PX_W-1:0]      it_size;

  logic [SIDX_W-1:0]    sidx;
  logic [CNT_W-1:0]     cnt;
  logic [DW-1:0]        dq;
  logic [PER_W-1:0]     rem;
  logic [PER_W-1:0]     cur_p;
  logic [DW-1:0]        dq_next;
  logic [PER_W-1:0]     rem_next;

  logic [NUM_SLOTS-1:0] hit;
  logic [NUM_SLOTS-1:0] roll;
  logic [NUM_SLOTS-1:0] emit_v;
  logic                 later_emit;
  logic                 out_busy;
  logic                 do_emit;
  logic                 s_acc;
  logic                 cfg_acc;
  logic [VOL_W:0]       vol_sum;
  logic [TIME_BITS-1:0] new_start;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_busy  = m_tvalid && !m_tready;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i]    = (slot_per[i] != '0) && (slot_inst[i] == it_inst);
      roll[i]   = {1'b0, it_t} >= bnd[i];
      emit_v[i] = bar_open[i] && ((it_op == OP_FLUSH) || (hit[i] && roll[i]));
    end
    later_emit = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i > int'(sidx) && emit_v[i]) begin
        later_emit = 1'b1;
      end
    end
  end

  assign do_emit = (state == S_SCAN) && emit_v[sidx] && !out_busy;

  always_comb begin
    logic [PER_W:0]  r;
    logic [DW-1:0]   q;
    r = {1'b0, rem};
    q = dq;
    for (int k = 0; k < RADIX_BITS; k++) begin
      r = {r[PER_W-1:0], q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (r >= {1'b0, cur_p}) begin
        r = r - {1'b0, cur_p};
      end
    end
    rem_next = r[PER_W-1:0];
    dq_next  = q;
  end

  assign vol_sum   = {1'b0, vol_v[sidx]} + (VOL_W+1)'(it_size);
  assign new_start = it_t - TIME_BITS'(rem);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!(emit_v[sidx] && out_busy)) begin
          if (it_op == OP_TICK && hit[sidx] && roll[sidx]) begin
            state_next = S_DIV;
          end else if (sidx == LAST_SLOT) begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (cnt == LAST_STEP) state_next = S_UPD;
      end
      S_UPD: begin
        state_next = (sidx == LAST_SLOT) ? S_IDLE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      m_tuser <= SLOT_W'(sidx);
      m_tlast <= !later_emit;
      m_tdata <= OUT_W'({tick_v[sidx], vol_v[sidx], close_v[sidx], low_v[sidx],
                         high_v[sidx], open_v[sidx], start_t[sidx], slot_per[sidx],
                         slot_inst[sidx]});
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      it_op    <= s_tuser;
      it_inst  <= s_tdata[INST_W-1:0];
      it_t     <= s_tdata[B_LO-1:T_LO];
      it_mid   <= {1'b0, s_tdata[A_LO-1:B_LO]} + {1'b0, s_tdata[H_LO-1:A_LO]};
      it_trade <= s_tdata[H_LO];
      it_size  <= s_tdata[Z_LO+PX_W-1:Z_LO];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sidx <= '0;
    end else if (s_acc) begin
      sidx <= '0;
    end else if (state == S_UPD ||
                 (state == S_SCAN && state_next == S_SCAN && !(emit_v[sidx] && out_busy))) begin
      sidx <= sidx + SIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && state_next == S_DIV) begin
      cnt   <= '0;
      rem   <= '0;
      dq    <= DW'(it_t);
      cur_p <= period_secs(slot_per[sidx]);
    end else if (state == S_DIV) begin
      cnt <= cnt + CNT_W'(1);
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_inst[i] <= '0;
        slot_per[i]  <= '0;
        bar_open[i]  <= 1'b0;
        bnd[i]       <= '0;
      end
    end else if (cfg_acc) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (cfg_index == CFG_INST_BASE + CIDX_W'(i)) begin
          slot_inst[i] <= cfg_data;
          bar_open[i]  <= 1'b0;
          bnd[i]       <= '0;
        end
        if (cfg_index == CFG_PER_BASE + CIDX_W'(i)) begin
          slot_per[i] <= cfg_data[CODE_W-1:0];
          bar_open[i] <= 1'b0;
          bnd[i]      <= '0;
        end
      end
    end else if (state == S_UPD) begin
      bar_open[sidx] <= 1'b1;
      bnd[sidx]      <= {1'b0, new_start} + (TIME_BITS+1)'(cur_p);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      start_t[sidx] <= new_start;
      open_v[sidx]  <= it_mid;
      high_v[sidx]  <= it_mid;
      low_v[sidx]   <= it_mid;
      close_v[sidx] <= it_mid;
      vol_v[sidx]   <= it_trade ? VOL_W'(it_size) : '0;
      tick_v[sidx]  <= TICK_W'(1);
    end else if (state == S_SCAN && it_op == OP_TICK && hit[sidx] && !roll[sidx]) begin
      if (it_mid > high_v[sidx]) high_v[sidx] <= it_mid;
      if (it_mid < low_v[sidx])  low_v[sidx]  <= it_mid;
      close_v[sidx] <= it_mid;
      if (it_trade) begin
        vol_v[sidx] <= vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
      end
      if (tick_v[sidx] != '1) tick_v[sidx] <= tick_v[sidx] + TICK_W'(1);
    end
  end

  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (rem < cur_p))
    else $error("alignment remainder not below period");

  a_cfg_drops_bar: assert property (@(posedge clk) disable iff (rst)
    (cfg_acc && cfg_index == CFG_INST_BASE) |=> !bar_open[0])
    else $error("config write kept slot bar open");

  a_busy_during_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (!s_tready && !cfg_ready))
    else $error("ready raised during alignment");

  a_last_once: assert property (@(posedge clk) disable iff (rst)
    (do_emit && !later_emit && sidx != LAST_SLOT) |=> !(state == S_SCAN && emit_v[sidx]))
    else $error("bar follows a last beat");

endmodule

// ----- test/ohlc_bar_aggregator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator_unit_tb
// Drives ticks and flushes through several slot setups and checks every bar
// beat against a bar book kept in the bench, with bursty input and stalls.
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ohlc_pkg::*;

  localparam int WD_LIMIT = 3000;
  localparam logic [39:0] T_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  slot;
    logic [15:0] inst;
    logic [2:0]  code;
    logic [39:0] start;
    logic [32:0] open_m;
    logic [32:0] high_m;
    logic [32:0] low_m;
    logic [32:0] close_m;
    logic [47:0] vol;
    logic [31:0] ticks;
    logic        last;
  } bar_t;

  class bar_book;
    logic [15:0] inst [4];
    logic [2:0]  code [4];
    bit          live [4];
    logic [40:0] bound [4];
    logic [39:0] start [4];
    logic [32:0] o_m [4];
    logic [32:0] h_m [4];
    logic [32:0] l_m [4];
    logic [32:0] c_m [4];
    logic [47:0] vol [4];
    logic [31:0] ticks [4];
    bar_t        due [$];
    int          errors;

    function void drop(int s);
      live[s] = 0; bound[s] = 0; start[s] = 0; o_m[s] = 0; h_m[s] = 0;
      l_m[s] = 0; c_m[s] = 0; vol[s] = 0; ticks[s] = 0;
    endfunction

    function void clear_all();
      for (int s = 0; s < 4; s++) begin
        inst[s] = 0; code[s] = 0; drop(s);
      end
      errors = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      if (idx < CFG_PER_BASE) begin
        inst[idx] = val; drop(idx);
      end else if (idx < CFG_END) begin
        code[idx - CFG_PER_BASE] = val[2:0]; drop(idx - CFG_PER_BASE);
      end
    endfunction

    function longint unsigned span(logic [2:0] c);
      case (c)
        3'd2: return 300;
        3'd3: return 900;
        3'd4: return 1800;
        3'd5: return 3600;
        3'd6: return 14400;
        3'd7: return 86400;
        default: return 60;
      endcase
    endfunction

    function bar_t snap(int s);
      bar_t b;
      b.slot = s; b.inst = inst[s]; b.code = code[s]; b.start = start[s];
      b.open_m = o_m[s]; b.high_m = h_m[s]; b.low_m = l_m[s]; b.close_m = c_m[s];
      b.vol = vol[s]; b.ticks = ticks[s]; b.last = 0;
      return b;
    endfunction

    function void note_beat(logic op, logic [15:0] ti, logic [39:0] t,
                            logic [31:0] bid, logic [31:0] ask, logic ht,
                            logic [31:0] sz);
      logic [32:0] mid;
      logic [48:0] v;
      longint unsigned p;
      bar_t out [$];
      mid = {1'b0, bid} + {1'b0, ask};
      for (int s = 0; s < 4; s++) begin
        if (op == OP_FLUSH) begin
          if (live[s]) out.push_back(snap(s));
          continue;
        end
        if (code[s] == 0 || inst[s] != ti) continue;
        if ({1'b0, t} >= bound[s]) begin
          p = span(code[s]);
          if (live[s]) out.push_back(snap(s));
          drop(s);
          start[s] = (t / p) * p;
          bound[s] = {1'b0, start[s]} + p;
        end
        if (!live[s]) begin
          o_m[s] = mid; h_m[s] = mid; l_m[s] = mid; live[s] = 1;
        end else begin
          if (mid > h_m[s]) h_m[s] = mid;
          if (mid < l_m[s]) l_m[s] = mid;
        end
        c_m[s] = mid;
        if (ht) begin
          v = {1'b0, vol[s]} + sz;
          vol[s] = v[48] ? 48'hFFFF_FFFF_FFFF : v[47:0];
        end
        if (ticks[s] != 32'hFFFF_FFFF) ticks[s]++;
      end
      if (out.size() > 0) out[out.size() - 1].last = 1;
      foreach (out[i]) due.push_back(out[i]);
    endfunction

    function void check_bar(bar_t got);
      bar_t exp_b;
      if (due.size() == 0) begin
        $error("bar beat with nothing pending: slot %0d", got.slot);
        errors++;
        return;
      end
      exp_b = due.pop_front();
      if (got.slot !== exp_b.slot) begin
        $error("slot exp %0d got %0d", exp_b.slot, got.slot); errors++;
      end
      if (got.inst !== exp_b.inst) begin
        $error("bar_instrument exp %0d got %0d", exp_b.inst, got.inst); errors++;
      end
      if (got.code !== exp_b.code) begin
        $error("bar_period exp %0d got %0d", exp_b.code, got.code); errors++;
      end
      if (got.start !== exp_b.start) begin
        $error("bar_start exp %0d got %0d", exp_b.start, got.start); errors++;
      end
      if (got.open_m !== exp_b.open_m) begin
        $error("open_mid exp %0d got %0d", exp_b.open_m, got.open_m); errors++;
      end
      if (got.high_m !== exp_b.high_m) begin
        $error("high_mid exp %0d got %0d", exp_b.high_m, got.high_m); errors++;
      end
      if (got.low_m !== exp_b.low_m) begin
        $error("low_mid exp %0d got %0d", exp_b.low_m, got.low_m); errors++;
      end
      if (got.close_m !== exp_b.close_m) begin
        $error("close_mid exp %0d got %0d", exp_b.close_m, got.close_m); errors++;
      end
      if (got.vol !== exp_b.vol) begin
        $error("volume exp %0d got %0d", exp_b.vol, got.vol); errors++;
      end
      if (got.ticks !== exp_b.ticks) begin
        $error("tick_total exp %0d got %0d", exp_b.ticks, got.ticks); errors++;
      end
      if (got.last !== exp_b.last) begin
        $error("last exp %0d got %0d", exp_b.last, got.last); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         s_tuser = OP_TICK;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [271:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  bar_book book;
  int burst_left = 0;
  int cyc = 0;
  int quiet = 0;
  int stall_mode = 0;
  logic [15:0] tracked [4];
  logic [39:0] now_t;

  ohlc_bar_aggregator_unit dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    bar_t got;
    cyc <= cyc + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[15:0], m_tdata[18:16], m_tdata[58:19], m_tdata[91:59],
             m_tdata[124:92], m_tdata[157:125], m_tdata[190:158], m_tdata[238:191],
             m_tdata[270:239], m_tlast};
      book.check_bar(got);
    end
    if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (cyc % 9 < 3);
    endcase
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(logic op, logic [15:0] ti, logic [39:0] t, logic [31:0] bid,
                      logic [31:0] ask, logic ht, logic [31:0] sz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {7'd0, sz, ht, ask, bid, t, ti};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_beat(op, ti, t, bid, ask, ht, sz);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (book.due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic setup(logic [15:0] i0, logic [15:0] i1, logic [15:0] i2,
                       logic [15:0] i3, logic [2:0] p0, logic [2:0] p1,
                       logic [2:0] p2, logic [2:0] p3);
    tracked = '{i0, i1, i2, i3};
    write_reg(CFG_INST_BASE + 0, i0);
    write_reg(CFG_INST_BASE + 1, i1);
    write_reg(CFG_INST_BASE + 2, i2);
    write_reg(CFG_INST_BASE + 3, i3);
    write_reg(CFG_PER_BASE + 0, {13'h1FFF, p0});
    write_reg(CFG_PER_BASE + 1, {13'd0, p1});
    write_reg(CFG_PER_BASE + 2, {13'd0, p2});
    write_reg(CFG_PER_BASE + 3, {13'd0, p3});
  endtask

  function automatic logic [31:0] rand_px();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 100);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] ti;
    logic [39:0] t;
    int sel;
    book = new();
    book.clear_all();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    setup(16'd0, 16'hFFFF, 16'd0, 16'd5, 3'd1, 3'd7, 3'd1, 3'd0);
    write_reg(CFG_END, 16'hFFFF);
    write_reg(4'hF, 16'h1234);
    send(OP_TICK, 16'd0, 40'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send(OP_TICK, 16'd0, 40'd59, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send(OP_TICK, 16'd0, 40'd30, 32'd7, 32'd3, 1'b1, 32'd1);
    send(OP_TICK, 16'd0, 40'd60, 32'd100, 32'd200, 1'b1, 32'd5);
    send(OP_TICK, 16'hFFFF, T_MAX, 32'd1, 32'd2, 1'b1, 32'hFFFF_FFFF);
    send(OP_TICK, 16'hFFFF, T_MAX, 32'd9, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send(OP_FLUSH, 16'hFFFF, T_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send(OP_TICK, 16'd5, 40'd1000, 32'd4, 32'd4, 1'b1, 32'd4);
    send(OP_TICK, 16'd77, 40'd1000, 32'd4, 32'd4, 1'b1, 32'd4);
    send(OP_TICK, 16'd0, 40'd200, 32'd50, 32'd50, 1'b1, 32'd10);
    send(OP_FLUSH, 16'd0, 40'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    drain();
    write_reg(CFG_PER_BASE + 1, 16'd3);
    send(OP_FLUSH, 16'd0, 40'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      setup((ph == 1) ? 16'hFFFF : 16'($urandom), 16'($urandom_range(0, 3)),
            16'($urandom_range(0, 3)), (ph == 2) ? 16'd0 : 16'($urandom),
            (ph == 0) ? 3'd1 : 3'($urandom), (ph == 1) ? 3'd7 : 3'($urandom),
            3'($urandom_range(1, 3)), (ph == 3) ? 3'd0 : 3'($urandom));
      case (ph % 3)
        0: now_t = $urandom_range(0, 5000);
        1: now_t = T_MAX - $urandom_range(0, 200000);
        default: now_t = {8'($urandom), 32'($urandom)};
      endcase
      for (int n = 0; n < 80; n++) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          send(OP_FLUSH, 16'($urandom), {8'($urandom), 32'($urandom)}, $urandom,
               $urandom, 1'($urandom), $urandom);
        end else if (sel == 1) begin
          send(OP_TICK, 16'($urandom), {8'($urandom), 32'($urandom)}, $urandom,
               $urandom, 1'($urandom), $urandom);
        end else begin
          ti = tracked[$urandom_range(0, 3)];
          case ($urandom_range(0, 9))
            0: t = now_t - $urandom_range(0, 120);
            1: t = now_t + $urandom_range(0, 200000);
            default: t = now_t + $urandom_range(0, 90);
          endcase
          if (t >= now_t) now_t = t;
          send(OP_TICK, ti, t, rand_px(), rand_px(), 1'($urandom), $urandom);
        end
        if (n == 40) drain();
      end
      send(OP_FLUSH, 16'd0, 40'd0, 32'd0, 32'd0, 1'b0, 32'd0);
      drain();
    end

    if (book.errors == 0 && book.due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/ohlc_pkg.sv
rtl/ohlc_bar_aggregator_unit.sv
test/ohlc_bar_aggregator_unit_tb.sv
